/* hdl/vertex_normal_averager_macros.svh */
`ifndef VERTEX_NORMAL_AVERAGER_MACROS_SVH
`define VERTEX_NORMAL_AVERAGER_MACROS_SVH

// same-cycle implication, checked outside reset
`define VNA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vna assertion failed");

// next-cycle implication, checked outside reset
`define VNA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vna assertion failed");

`endif

/* hdl/vna_pkg.sv */
`timescale 1ns / 1ps
package vna_pkg;
    localparam int MAX_VERTICES = 4096;
    localparam int ACCUM_BITS   = 24;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int IDX_W        = 16;
    localparam int CRD_W        = 16;
    localparam int POS_W        = 3 * CRD_W;
    localparam int ACC_W        = 3 * ACCUM_BITS;
    localparam int DIFF_W       = CRD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CR_W         = PROD_W + 1;
    localparam int NRM_W        = 16;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic signed [NRM_W-1:0] z;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] x;
    } norm_t;
endpackage

/* hdl/vertex_normal_averager.sv */
`timescale 1ns / 1ps
// Smoothed vertex normal averager. Opcode 0 stores a Q4.12 vertex position and
// clears its normal accumulator, opcode 1 adds a triangle's unit face normal to
// its three corners (saturating), opcode 2 returns a vertex's accumulated
// normal normalized to Q1.14. Each transaction gives one result; status 1 flags
// an index at or above MAX_VERTICES. Positions and accumulators sit in two
// single-port-write RAMs with registered reads. After reset the accumulator
// RAM is cleared, one entry a cycle, with s_tready low. The normalizer shifts,
// then runs 5 squaring steps, a 31-step square root and three 15-step
// restoring divisions, skipping the divisions when the vector is zero. One
// transaction is worked at a time; the output register lets the next one
// start while a result waits.
module vertex_normal_averager import vna_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_first, corner_second, corner_third
    input  logic [111:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x, normal_y, normal_z
    output logic [47:0]  m_tdata,
    // status
    output logic [0:0]   m_tuser
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_P0, S_P1, S_P2, S_P3, S_DIFF, S_CROSS, S_UGO,
        S_UWAIT, S_ACC_RD, S_ACC_WR, S_RD_RD, S_RD_D, S_FIN
    } state_t;

    state_t                    state_reg;
    logic [ADDR_W-1:0]         clr_reg;
    logic [ADDR_W-1:0]         corner_reg [3];
    logic [ADDR_W-1:0]         vi_reg;
    logic [POS_W-1:0]          p_reg [3];
    logic signed [DIFF_W-1:0]  a_reg [3];
    logic signed [DIFF_W-1:0]  b_reg [3];
    logic signed [PROD_W-1:0]  prod_reg;
    logic [2:0]                pk_reg;
    logic signed [CR_W-1:0]    cr_reg [3];
    logic [2:0]                cnt_reg;
    logic [1:0]                k_reg;
    logic                      is_read_reg;
    logic                      status_reg;
    norm_t                     norm_reg;
    logic                      m_tvalid_reg;
    logic [47:0]               m_tdata_reg;
    logic                      m_tuser_reg;

    logic                      accept;
    op_t                       op;
    logic [IDX_W-1:0]          vi_in;
    logic [IDX_W-1:0]          c_in [3];
    logic                      vi_bad;
    logic                      tri_bad;

    logic                      pos_we;
    logic [ADDR_W-1:0]         pos_raddr;
    logic [POS_W-1:0]          pos_rdata;
    logic                      acc_we;
    logic [ADDR_W-1:0]         acc_waddr;
    logic [ACC_W-1:0]          acc_wdata;
    logic [ADDR_W-1:0]         acc_raddr;
    logic [ACC_W-1:0]          acc_rdata;

    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic                      unit_start;
    logic signed [CR_W-1:0]    unit_in [3];
    logic                      unit_done;
    norm_t                     unit_res;
    logic signed [NRM_W-1:0]   u_comp [3];
    logic [ACC_W-1:0]          acc_sum;

    assign accept = s_tvalid && s_tready;
    assign op     = op_t'(s_tuser);
    assign vi_in  = s_tdata[15:0];
    assign c_in[0] = s_tdata[79:64];
    assign c_in[1] = s_tdata[95:80];
    assign c_in[2] = s_tdata[111:96];
    assign vi_bad = {1'b0, vi_in} >= (IDX_W+1)'(MAX_VERTICES);
    assign tri_bad = ({1'b0, c_in[0]} >= (IDX_W+1)'(MAX_VERTICES))
                  || ({1'b0, c_in[1]} >= (IDX_W+1)'(MAX_VERTICES))
                  || ({1'b0, c_in[2]} >= (IDX_W+1)'(MAX_VERTICES));

    assign pos_we = accept && op == OP_STORE && !vi_bad;

    always_comb begin
        case (state_reg)
            S_P1:    pos_raddr = corner_reg[1];
            S_P2:    pos_raddr = corner_reg[2];
            default: pos_raddr = corner_reg[0];
        endcase
        acc_raddr = (state_reg == S_ACC_RD) ? corner_reg[k_reg] : vi_reg;

        u_comp[0] = unit_res.x;
        u_comp[1] = unit_res.y;
        u_comp[2] = unit_res.z;
        for (int i = 0; i < 3; i++) begin
            logic signed [ACCUM_BITS:0] s;
            s = (ACCUM_BITS+1)'(signed'(acc_rdata[i*ACCUM_BITS +: ACCUM_BITS]))
              + (ACCUM_BITS+1)'(u_comp[i]);
            if (s[ACCUM_BITS] != s[ACCUM_BITS-1]) begin
                acc_sum[i*ACCUM_BITS +: ACCUM_BITS] =
                    {s[ACCUM_BITS], {(ACCUM_BITS-1){!s[ACCUM_BITS]}}};
            end else begin
                acc_sum[i*ACCUM_BITS +: ACCUM_BITS] = s[ACCUM_BITS-1:0];
            end
        end

        acc_we    = 1'b0;
        acc_waddr = vi_in[ADDR_W-1:0];
        acc_wdata = '0;
        if (state_reg == S_CLR) begin
            acc_we    = 1'b1;
            acc_waddr = clr_reg;
        end else if (pos_we) begin
            acc_we    = 1'b1;
        end else if (state_reg == S_ACC_WR) begin
            acc_we    = 1'b1;
            acc_waddr = corner_reg[k_reg];
            acc_wdata = acc_sum;
        end

        case (cnt_reg)
            3'd0:    begin mul_a = a_reg[1]; mul_b = b_reg[2]; end
            3'd1:    begin mul_a = a_reg[2]; mul_b = b_reg[1]; end
            3'd2:    begin mul_a = a_reg[2]; mul_b = b_reg[0]; end
            3'd3:    begin mul_a = a_reg[0]; mul_b = b_reg[2]; end
            3'd4:    begin mul_a = a_reg[0]; mul_b = b_reg[1]; end
            3'd5:    begin mul_a = a_reg[1]; mul_b = b_reg[0]; end
            default: begin mul_a = '0;       mul_b = '0;       end
        endcase

        unit_start = (state_reg == S_UGO) || (state_reg == S_RD_D);
        for (int i = 0; i < 3; i++) begin
            if (is_read_reg) begin
                unit_in[i] = CR_W'(signed'(acc_rdata[i*ACCUM_BITS +: ACCUM_BITS]));
            end else begin
                unit_in[i] = cr_reg[i];
            end
        end
    end

    vna_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (vi_in[ADDR_W-1:0]),
        .wdata (s_tdata[63:16]),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(ACC_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    vna_unitize u_unitize (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .vec_in  (unit_in),
        .done    (unit_done),
        .result  (unit_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(MAX_VERTICES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        vi_reg      <= vi_in[ADDR_W-1:0];
                        for (int i = 0; i < 3; i++) begin
                            corner_reg[i] <= c_in[i][ADDR_W-1:0];
                        end
                        is_read_reg <= (op == OP_READ);
                        status_reg  <= STATUS_OK;
                        norm_reg    <= '0;
                        state_reg   <= S_FIN;
                        case (op)
                            OP_STORE: begin
                                if (vi_bad) begin
                                    status_reg <= STATUS_RANGE;
                                end
                            end
                            OP_TRI: begin
                                if (tri_bad) begin
                                    status_reg <= STATUS_RANGE;
                                end else begin
                                    state_reg <= S_P0;
                                end
                            end
                            OP_READ: begin
                                if (vi_bad) begin
                                    status_reg <= STATUS_RANGE;
                                end else begin
                                    state_reg <= S_RD_RD;
                                end
                            end
                            default: begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_P0: state_reg <= S_P1;
                S_P1: begin
                    p_reg[0]  <= pos_rdata;
                    state_reg <= S_P2;
                end
                S_P2: begin
                    p_reg[1]  <= pos_rdata;
                    state_reg <= S_P3;
                end
                S_P3: begin
                    p_reg[2]  <= pos_rdata;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        a_reg[i] <= DIFF_W'(signed'(p_reg[1][i*CRD_W +: CRD_W]))
                                  - DIFF_W'(signed'(p_reg[0][i*CRD_W +: CRD_W]));
                        b_reg[i] <= DIFF_W'(signed'(p_reg[2][i*CRD_W +: CRD_W]))
                                  - DIFF_W'(signed'(p_reg[0][i*CRD_W +: CRD_W]));
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_CROSS;
                end
                S_CROSS: begin
                    if (cnt_reg != 3'd6) begin
                        prod_reg <= mul_a * mul_b;
                        pk_reg   <= cnt_reg;
                    end
                    if (cnt_reg != 3'd0) begin
                        case (pk_reg)
                            3'd0:    cr_reg[0] <= CR_W'(prod_reg);
                            3'd1:    cr_reg[0] <= cr_reg[0] - CR_W'(prod_reg);
                            3'd2:    cr_reg[1] <= CR_W'(prod_reg);
                            3'd3:    cr_reg[1] <= cr_reg[1] - CR_W'(prod_reg);
                            3'd4:    cr_reg[2] <= CR_W'(prod_reg);
                            3'd5:    cr_reg[2] <= cr_reg[2] - CR_W'(prod_reg);
                            default: cr_reg[0] <= cr_reg[0];
                        endcase
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd6) begin
                        state_reg <= S_UGO;
                    end
                end
                S_UGO: state_reg <= S_UWAIT;
                S_UWAIT: begin
                    if (unit_done) begin
                        k_reg <= '0;
                        if (is_read_reg) begin
                            norm_reg  <= unit_res;
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= S_ACC_RD;
                        end
                    end
                end
                S_ACC_RD: state_reg <= S_ACC_WR;
                S_ACC_WR: begin
                    k_reg <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd2) ? S_FIN : S_ACC_RD;
                end
                S_RD_RD: state_reg <= S_RD_D;
                S_RD_D:  state_reg <= S_UWAIT;
                S_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= norm_reg;
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule

/* hdl/vna_ram.sv */
`timescale 1ns / 1ps
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/vna_unitize.sv */
`timescale 1ns / 1ps
module vna_unitize import vna_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [CR_W-1:0] vec_in [3],
    output logic                   done,
    output norm_t                  result
);
    typedef enum logic [2:0] {
        U_IDLE, U_SHIFT, U_SQ, U_SQRT, U_DINIT, U_DIV, U_STORE, U_DONE
    } u_state_t;

    u_state_t         state_reg;
    logic [CR_W-1:0]  mag_reg [3];
    logic             neg_reg [3];
    logic [29:0]      m_reg [3];
    logic [59:0]      sqp_reg;
    logic [61:0]      sum_reg;
    logic [61:0]      v_reg;
    logic [61:0]      res_reg;
    logic [61:0]      bit_reg;
    logic [4:0]       cnt_reg;
    logic [1:0]       comp_reg;
    logic [45:0]      rem_reg;
    logic [46:0]      dsh_reg;
    logic [14:0]      q_reg;
    norm_t            result_reg;

    logic [CR_W-1:0]  mx;
    logic [2:0]       shamt;
    logic [29:0]      sq_op;
    logic [61:0]      trial;
    logic [30:0]      root;
    logic [NRM_W-1:0] q_ext;
    logic [NRM_W-1:0] q_signed;

    always_comb begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx) begin
            mx = mag_reg[2];
        end
        shamt = 3'd0;
        for (int i = 30; i < CR_W; i++) begin
            if (mx[i]) begin
                shamt = 3'(i - 29);
            end
        end
        case (cnt_reg[1:0])
            2'd0:    sq_op = m_reg[0];
            2'd1:    sq_op = m_reg[1];
            2'd2:    sq_op = m_reg[2];
            default: sq_op = '0;
        endcase
        trial    = res_reg + bit_reg;
        root     = res_reg[30:0];
        q_ext    = NRM_W'(q_reg);
        q_signed = neg_reg[comp_reg] ? -q_ext : q_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            case (state_reg)
                U_IDLE: begin
                    if (start) begin
                        for (int i = 0; i < 3; i++) begin
                            neg_reg[i] <= vec_in[i][CR_W-1];
                            mag_reg[i] <= vec_in[i][CR_W-1] ? CR_W'(-vec_in[i])
                                                             : CR_W'(vec_in[i]);
                        end
                        state_reg <= U_SHIFT;
                    end
                end
                U_SHIFT: begin
                    for (int i = 0; i < 3; i++) begin
                        m_reg[i] <= 30'(mag_reg[i] >> shamt);
                    end
                    sum_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= U_SQ;
                end
                U_SQ: begin
                    if (cnt_reg < 5'd3) begin
                        sqp_reg <= sq_op * sq_op;
                    end
                    if (cnt_reg != 5'd0 && cnt_reg < 5'd4) begin
                        sum_reg <= sum_reg + 62'(sqp_reg);
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd4) begin
                        v_reg     <= sum_reg;
                        res_reg   <= '0;
                        bit_reg   <= 62'd1 << 60;
                        cnt_reg   <= 5'd30;
                        state_reg <= U_SQRT;
                    end
                end
                U_SQRT: begin
                    if (v_reg >= trial) begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        comp_reg  <= '0;
                        state_reg <= U_DINIT;
                    end
                end
                U_DINIT: begin
                    if (root == '0) begin
                        result_reg <= '0;
                        state_reg  <= U_DONE;
                    end else begin
                        rem_reg   <= {1'b0, m_reg[comp_reg], 15'd0} + 46'(root);
                        dsh_reg   <= 47'(root) << 15;
                        q_reg     <= '0;
                        cnt_reg   <= 5'd14;
                        state_reg <= U_DIV;
                    end
                end
                U_DIV: begin
                    if (47'(rem_reg) >= dsh_reg) begin
                        rem_reg <= rem_reg - 46'(dsh_reg);
                        q_reg   <= {q_reg[13:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[13:0], 1'b0};
                    end
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= U_STORE;
                    end
                end
                U_STORE: begin
                    case (comp_reg)
                        2'd0:    result_reg.x <= q_signed;
                        2'd1:    result_reg.y <= q_signed;
                        2'd2:    result_reg.z <= q_signed;
                        default: result_reg.x <= q_signed;
                    endcase
                    if (comp_reg == 2'd2) begin
                        state_reg <= U_DONE;
                    end else begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= U_DINIT;
                    end
                end
                U_DONE: begin
                    state_reg <= U_IDLE;
                end
                default: begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = (state_reg == U_DONE);
    assign result = result_reg;
endmodule

/* hdl/vna_checker.sv */
`timescale 1ns / 1ps
`include "vertex_normal_averager_macros.svh"
module vna_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata,
    input logic [0:0]   m_tuser
);
    // a stalled result transaction keeps its payload
    `VNA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // an error result carries a zero normal
    `VNA_ASSERT_IMP(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 48'd0)
    // one transaction in work at a time
    `VNA_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // accumulator clearing holds off input right after reset
    `VNA_ASSERT_IMP(a_clear_after_reset, aclk, aresetn, $past(!aresetn), !s_tready && !m_tvalid)
endmodule

bind vertex_normal_averager vna_checker u_vna_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
